// ===== rtl/lcoc_pkg.sv =====
package lcoc_pkg;

	localparam int DEF_MAX_BEADS = 1024;
	localparam int IDX_W   = 10;
	localparam int CRD_W   = 16;
	localparam int CAND_W  = CRD_W + 2;
	localparam int POS_W   = 13;
	localparam int N_CAND  = 16;
	localparam int MOVE_W  = 36;
	localparam int FOLLOW_W = 24;
	localparam int CFG_W   = 36;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MOVES_SUB0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVES_SUB1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOLLOW     = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] M_PLAIN  = 3'd0;
	localparam logic [2:0] M_ONE    = 3'd1;
	localparam logic [2:0] M_TWO    = 3'd2;
	localparam logic [2:0] M_FRAG   = 3'd3;
	localparam logic [2:0] M_BRICK  = 3'd4;
	localparam logic [2:0] M_FBRICK = 3'd5;
	localparam logic [2:0] M_WHOLE  = 3'd6;
	localparam logic [2:0] M_UNUSED = 3'd7;

	typedef struct packed {
		logic op;
		logic [2:0] mode;
	} req_info_t;

	typedef struct packed {
		logic accept;
		logic rd_base;
		logic build;
		logic scan;
		logic next_i;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic exhausted;
		logic i_ok;
	} dp_stat_t;

	function automatic logic signed [CAND_W-1:0] move_comp(input logic [MOVE_W-1:0] tbl,
			input logic [1:0] k, input logic [1:0] c);
		logic [5:0] sh;
		logic [2:0] v;
		sh = 6'(k) * 6'd9 + 6'(c) * 6'd3;
		v = 3'(tbl >> sh);
		return CAND_W'($signed(v));
	endfunction

	function automatic logic [1:0] follow_mv(input logic [FOLLOW_W-1:0] ft,
			input logic [1:0] m, input logic [1:0] t);
		logic [4:0] sh;
		sh = 5'(m) * 5'd6 + 5'(t) * 5'd2;
		return 2'(ft >> sh);
	endfunction

endpackage

// ===== rtl/lcoc_req_if.sv =====
interface lcoc_req_if;
	import lcoc_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic [IDX_W-1:0] bead_index;
	logic signed [CRD_W-1:0] coord_x;
	logic signed [CRD_W-1:0] coord_y;
	logic signed [CRD_W-1:0] coord_z;
	logic [2:0] mode;
	logic [1:0] last_move;
	logic parity;
	logic [IDX_W-1:0] start_index;
	logic [IDX_W-1:0] end_index;
	logic [IDX_W-1:0] brick_pos;

	modport source (output valid, op, bead_index, coord_x, coord_y, coord_z, mode,
		last_move, parity, start_index, end_index, brick_pos, input ready);
	modport sink (input valid, op, bead_index, coord_x, coord_y, coord_z, mode,
		last_move, parity, start_index, end_index, brick_pos, output ready);
endinterface

// ===== rtl/lcoc_res_if.sv =====
interface lcoc_res_if;
	logic valid;
	logic ready;
	logic collision;
	logic was_query;

	modport source (output valid, collision, was_query, input ready);
	modport sink (input valid, collision, was_query, output ready);
endinterface

// ===== rtl/lcoc_ctrl.sv =====
module lcoc_ctrl
	import lcoc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  req_info_t info,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      collision,
	output logic      was_query,
	output dp_cmd_t   cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_BASE  = 5'b00010,
		S_BUILD = 5'b00100,
		S_SCAN  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic whole_q, query_q, hit_q;
	logic res_valid_q, res_col_q, res_wq_q;
	logic set_hit, clr_hit, load_res;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = res_valid_q;
	assign collision = res_col_q;
	assign was_query = res_wq_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		set_hit = 1'b0;
		clr_hit = 1'b0;
		load_res = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					clr_hit = 1'b1;
					if (info.op == OP_WRITE || info.mode == M_UNUSED) state_d = S_FIN;
					else state_d = S_BASE;
				end
			end
			S_BASE: begin
				cmd.rd_base = 1'b1;
				if (whole_q && !stat.i_ok) state_d = S_FIN;
				else state_d = S_BUILD;
			end
			S_BUILD: begin
				cmd.build = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					set_hit = 1'b1;
					state_d = S_FIN;
				end else if (stat.exhausted) begin
					if (whole_q) begin
						cmd.next_i = 1'b1;
						state_d = S_BASE;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (!res_valid_q || out_ready) begin
					load_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			hit_q <= 1'b0;
			whole_q <= 1'b0;
			query_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				whole_q <= (info.mode == M_WHOLE);
				query_q <= (info.op == OP_QUERY);
			end
			if (clr_hit) hit_q <= 1'b0;
			else if (set_hit) hit_q <= 1'b1;
			if (load_res) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_col_q <= hit_q;
			res_wq_q <= query_q;
		end
	end

endmodule

// ===== rtl/lcoc_dp.sv =====
module lcoc_dp
	import lcoc_pkg::*;
#(
	parameter int MAX_BEADS = DEF_MAX_BEADS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic                    op,
	input  logic [IDX_W-1:0]        bead_index,
	input  logic signed [CRD_W-1:0] coord_x,
	input  logic signed [CRD_W-1:0] coord_y,
	input  logic signed [CRD_W-1:0] coord_z,
	input  logic [2:0]              mode,
	input  logic [1:0]              last_move,
	input  logic                    parity,
	input  logic [IDX_W-1:0]        start_index,
	input  logic [IDX_W-1:0]        end_index,
	input  logic [IDX_W-1:0]        brick_pos,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int AW = (MAX_BEADS > 1) ? $clog2(MAX_BEADS) : 1;

	logic [3*CRD_W-1:0] mem [MAX_BEADS];

	logic [MOVE_W-1:0]   moves0_q, moves1_q;
	logic [FOLLOW_W-1:0] follow_q;

	logic [IDX_W-1:0] pos_q, start_q, end_q, bpos_q;
	logic [2:0]       mode_q;
	logic [1:0]       last_q;
	logic             odd_q;
	logic [IDX_W:0]   i_q;

	logic signed [POS_W-1:0] t_q, lo_q, hi_d, lo_d, rd_pos;
	logic cmp_v_q;
	logic [3*CRD_W-1:0] rd_q;
	logic rd_ok_q, rd_ok;
	logic [31:0] rd_pos32;

	logic signed [CAND_W-1:0] cand_q [N_CAND][3];
	logic [N_CAND-1:0]        cand_v_q;
	logic signed [CAND_W-1:0] cand_d [N_CAND][3];
	logic [N_CAND-1:0]        cand_v_d;
	logic signed [CAND_W-1:0] seen [3];
	logic [N_CAND-1:0]        match;
	logic issue_ok;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moves0_q <= '0;
			moves1_q <= '0;
			follow_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MOVES_SUB0: moves0_q <= cfg_data[MOVE_W-1:0];
				REG_MOVES_SUB1: moves1_q <= cfg_data[MOVE_W-1:0];
				REG_FOLLOW:     follow_q <= cfg_data[FOLLOW_W-1:0];
				default: ;
			endcase
		end
	end

	// request fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q <= bead_index;
			start_q <= start_index;
			end_q <= end_index;
			bpos_q <= brick_pos;
			mode_q <= mode;
			last_q <= last_move;
			odd_q <= parity;
			i_q <= {1'b0, start_index} + 1'b1;
		end else if (cmd.next_i) begin
			i_q <= i_q + 1'b1;
		end
	end

	// bead memory
	always_ff @(posedge clk) begin
		if (cmd.accept && op == OP_WRITE && int'(bead_index) < MAX_BEADS)
			mem[AW'({{(32-IDX_W){1'b0}}, bead_index})] <= {coord_z, coord_y, coord_x};
	end

	always_comb begin
		if (cmd.rd_base) begin
			if (mode_q == M_WHOLE) rd_pos = POS_W'(i_q);
			else rd_pos = POS_W'(pos_q);
		end else begin
			rd_pos = t_q;
		end
		rd_pos32 = 32'(unsigned'(rd_pos));
		rd_ok = !rd_pos[POS_W-1] && int'(rd_pos) < MAX_BEADS;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_pos32[AW-1:0]];
		rd_ok_q <= rd_ok;
	end

	always_comb begin
		seen[0] = rd_ok_q ? CAND_W'($signed(rd_q[CRD_W-1:0])) : '0;
		seen[1] = rd_ok_q ? CAND_W'($signed(rd_q[2*CRD_W-1:CRD_W])) : '0;
		seen[2] = rd_ok_q ? CAND_W'($signed(rd_q[3*CRD_W-1:2*CRD_W])) : '0;
	end

	// search bounds
	always_comb begin
		int p, s, b, st;
		p = int'(pos_q);
		b = int'(bpos_q);
		st = int'(start_q);
		s = b - 3;
		if (s % 2 != 0) s = (s < 0) ? s - 1 : s + 1;
		lo_d = '0;
		case (mode_q)
			M_PLAIN:  hi_d = POS_W'(p - 6);
			M_ONE:    hi_d = POS_W'(p - 5);
			M_TWO:    hi_d = POS_W'(p - 4);
			M_FRAG: begin
				hi_d = POS_W'(p - 4);
				lo_d = POS_W'(st);
			end
			M_BRICK:  hi_d = POS_W'(b - int'(odd_q));
			M_FBRICK: begin
				hi_d = POS_W'(p - 4 - s);
				lo_d = POS_W'(st);
			end
			M_WHOLE:  hi_d = POS_W'(st - int'(i_q[0]) - ((int'(i_q) <= st + 2) ? 2 : 0));
			default:  hi_d = '1;
		endcase
	end

	// candidate positions from the base bead
	always_comb begin
		logic par;
		logic [MOVE_W-1:0] tbl1, tbl2;
		logic [1:0] m1, m2;
		logic u1, u2;
		par = (mode_q == M_WHOLE) ? i_q[0] : odd_q;
		tbl1 = par ? moves0_q : moves1_q;
		tbl2 = par ? moves1_q : moves0_q;
		for (int k = 0; k < N_CAND; k++) begin
			m1 = '0;
			m2 = '0;
			u1 = 1'b0;
			u2 = 1'b0;
			case (mode_q)
				M_PLAIN: cand_v_d[k] = (k == 0);
				M_ONE: begin
					m1 = follow_mv(follow_q, last_q, 2'(k));
					u1 = 1'b1;
					cand_v_d[k] = (k < 3);
				end
				M_WHOLE: begin
					m1 = 2'(k / 4);
					m2 = 2'(k % 4);
					u1 = 1'b1;
					u2 = 1'b1;
					cand_v_d[k] = 1'b1;
				end
				default: begin
					m1 = follow_mv(follow_q, last_q, 2'(k / 3));
					m2 = follow_mv(follow_q, m1, 2'(k % 3));
					u1 = 1'b1;
					u2 = 1'b1;
					cand_v_d[k] = (k < 9);
				end
			endcase
			for (int c = 0; c < 3; c++) begin
				cand_d[k][c] = seen[c]
					+ (u1 ? move_comp(tbl1, m1, 2'(c)) : CAND_W'(0))
					+ (u2 ? move_comp(tbl2, m2, 2'(c)) : CAND_W'(0));
			end
		end
	end

	assign issue_ok = (t_q >= lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_q <= 1'b0;
		end else if (cmd.build) begin
			cmp_v_q <= 1'b0;
		end else if (cmd.scan) begin
			cmp_v_q <= issue_ok;
		end else begin
			cmp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			t_q <= hi_d;
			lo_q <= lo_d;
			cand_q <= cand_d;
			cand_v_q <= cand_v_d;
		end else if (cmd.scan && issue_ok) begin
			t_q <= t_q - POS_W'(2);
		end
	end

	always_comb begin
		for (int k = 0; k < N_CAND; k++)
			match[k] = cand_v_q[k] && cand_q[k][0] == seen[0]
				&& cand_q[k][1] == seen[1] && cand_q[k][2] == seen[2];
	end

	assign stat.hit = cmp_v_q && (|match);
	assign stat.exhausted = !issue_ok && !cmp_v_q;
	assign stat.i_ok = (i_q <= {1'b0, end_q});

endmodule

// ===== rtl/lattice_chain_overlap_check.sv =====
// a write goes from accept straight to posting its result; a query reads the base bead,
// builds candidates, scans every second bead down to the lower bound, drains the compare
// and posts the result; whole-fragment scans repeat base read, build and scan per bead
// of the fragment; one request at a time
// reset: arst_n clears the controller, result valid and the move and follow tables;
// the bead memory holds no reset value and must be written before it is read
module lattice_chain_overlap_check
	import lcoc_pkg::*;
#(
	parameter int MAX_BEADS = DEF_MAX_BEADS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lcoc_req_if.sink             in_ch,
	lcoc_res_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	req_info_t info;

	// op and mode steer the controller's first decision on a request
	assign info.op   = in_ch.op;
	assign info.mode = in_ch.mode;

	// sequencer: accept, read base bead, build candidates, scan, post result
	lcoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.info      (info),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.collision (out_ch.collision),
		.was_query (out_ch.was_query),
		.cmd       (cmd),
		.stat      (stat)
	);

	// bead memory, tables, candidate registers and the scan compare
	lcoc_dp #(
		.MAX_BEADS (MAX_BEADS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (in_ch.op),
		.bead_index  (in_ch.bead_index),
		.coord_x     (in_ch.coord_x),
		.coord_y     (in_ch.coord_y),
		.coord_z     (in_ch.coord_z),
		.mode        (in_ch.mode),
		.last_move   (in_ch.last_move),
		.parity      (in_ch.parity),
		.start_index (in_ch.start_index),
		.end_index   (in_ch.end_index),
		.brick_pos   (in_ch.brick_pos),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data)
	);

endmodule

// ===== rtl/lcoc_checker.sv =====
module lcoc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic collision,
	input logic was_query
);

	// result held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(collision) && $stable(was_query))
		else $error("result payload changed while stalled");

	// block busy in the cycle after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a write never reports an overlap
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !was_query |-> !collision)
		else $error("write result flags a collision");

endmodule

bind lattice_chain_overlap_check lcoc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.collision (out_ch.collision),
	.was_query (out_ch.was_query)
);
